### src/key_debounce_event_fifo_assert.svh
// Assertion macros for the key debounce event queue.
// The macros expect clk and rst_n in scope at the point of use.
`ifndef KEY_DEBOUNCE_EVENT_FIFO_ASSERT_SVH
`define KEY_DEBOUNCE_EVENT_FIFO_ASSERT_SVH
`ifndef SYNTH
`define KDEF_ASSERT(label, prop) label: assert property (@(posedge clk) disable iff (!rst_n) \
    prop) else $error("kdef assertion failed");
`define KDEF_ASSERT_ALWAYS(label, prop) label: assert property (@(posedge clk) prop) \
    else $error("kdef assertion failed");
`else
`define KDEF_ASSERT(label, prop)
`define KDEF_ASSERT_ALWAYS(label, prop)
`endif
`endif

### src/kdef_pkg.sv
// Shared types and constants for the key debounce event queue.
// No dependencies.
package kdef_pkg;

    localparam int QUEUE_DEPTH = 16;
    localparam int IDX_W       = $clog2(QUEUE_DEPTH);
    localparam int BANK_DEPTH  = QUEUE_DEPTH / 2;
    localparam int BANK_W      = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;
    localparam int PADDR_W     = 5;
    localparam int PDATA_W     = 32;

    typedef enum logic [1:0] {
        OP_TICK    = 2'd0,
        OP_DEQUEUE = 2'd1,
        OP_CLEAR   = 2'd2
    } opcode_t;

    typedef enum logic [2:0] {
        EV_NONE  = 3'd0,
        EV_DOWN  = 3'd1,
        EV_LONG  = 3'd2,
        EV_SHORT = 3'd3,
        EV_UP    = 3'd4
    } tick_event_t;

    typedef enum logic [1:0] {
        KIND_DOWN  = 2'd0,
        KIND_LONG  = 2'd1,
        KIND_SHORT = 2'd2,
        KIND_UP    = 2'd3
    } ev_kind_t;

    typedef enum logic [2:0] {
        REG_KEY_NUMBER  = 3'd0,
        REG_FILTER      = 3'd1,
        REG_LONG_HOLD   = 3'd2,
        REG_SHORT_HOLD  = 3'd3,
        REG_REPEAT      = 3'd4
    } reg_index_t;

    typedef struct packed {
        opcode_t opcode;
        logic    key_pressed;
    } req_t;

    typedef struct packed {
        tick_event_t tick_event;
        logic        entry_valid;
        logic [5:0]  entry_key;
        ev_kind_t    entry_kind;
    } rsp_t;

    typedef struct packed {
        logic [5:0] key;
        ev_kind_t   kind;
    } entry_t;

    function automatic logic [IDX_W-1:0] idx_inc(input logic [IDX_W-1:0] idx);
        return (idx == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : idx + IDX_W'(1);
    endfunction

    function automatic logic [BANK_W-1:0] bank_addr(input logic [IDX_W-1:0] idx);
        return BANK_W'(idx >> 1);
    endfunction

endpackage

### src/key_debounce_event_fifo.sv
// Key debounce with long press, auto-repeat and a ring event queue in two RAM banks.
// Pipeline: first stage, then output register; one item per cycle unless rsp stalls.
// Two queued events per tick fit because consecutive slots sit in opposite banks.
// Reset: asynchronous, active low; clears counters, indices and config to defaults.
// Depends on kdef_pkg and key_debounce_event_fifo_assert.svh; queue RAM is not cleared.
`include "key_debounce_event_fifo_assert.svh"

module key_debounce_event_fifo (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              req_valid,
    output logic                              req_ready,
    input  kdef_pkg::req_t                    req,
    output logic                              rsp_valid,
    input  logic                              rsp_ready,
    output kdef_pkg::rsp_t                    rsp,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [kdef_pkg::PADDR_W-1:0]      paddr,
    input  logic [kdef_pkg::PDATA_W-1:0]      pwdata,
    output logic [kdef_pkg::PDATA_W-1:0]      prdata,
    output logic                              pready
);
    import kdef_pkg::*;

    logic [5:0]       key_number_reg;
    logic [7:0]       filter_ticks_reg;
    logic [15:0]      long_hold_reg;
    logic [15:0]      short_hold_reg;
    logic [7:0]       repeat_ticks_reg;

    logic [8:0]       filter_count_reg, filter_count_next;
    logic             is_down_reg, is_down_next;
    logic [15:0]      hold_count_reg, hold_count_next;
    logic [7:0]       repeat_count_reg, repeat_count_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic [IDX_W-1:0] wr_idx_reg, wr_idx_next;

    entry_t           bank0_mem [BANK_DEPTH];
    entry_t           bank1_mem [BANK_DEPTH];
    entry_t           bank0_q_reg, bank1_q_reg;

    logic             s1_valid_reg;
    tick_event_t      s1_tick_event_reg;
    logic             s1_entry_valid_reg;
    logic             s1_bank_reg;
    logic             out_valid_reg;
    rsp_t             out_reg, out_next;

    logic             req_fire, out_free, do_tick, do_deq, do_clear, q_empty;
    logic             cfg_write;
    tick_event_t      tick_ev;
    logic             push_a, push_b;
    ev_kind_t         kind_a, kind_b;
    logic             slot0_v, slot1_v;
    ev_kind_t         slot0_kind;
    logic [IDX_W-1:0] wr_idx_p1;
    logic             bank0_we, bank1_we;
    logic [BANK_W-1:0] bank0_wa, bank1_wa;
    entry_t           bank0_wd, bank1_wd;
    entry_t           q_sel;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            key_number_reg   <= '0;
            filter_ticks_reg <= 8'd5;
            long_hold_reg    <= '0;
            short_hold_reg   <= '0;
            repeat_ticks_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (reg_index_t'(paddr[4:2]))
                REG_KEY_NUMBER: key_number_reg   <= pwdata[5:0];
                REG_FILTER:     filter_ticks_reg <= pwdata[7:0];
                REG_LONG_HOLD:  long_hold_reg    <= pwdata[15:0];
                REG_SHORT_HOLD: short_hold_reg   <= pwdata[15:0];
                REG_REPEAT:     repeat_ticks_reg <= pwdata[7:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (reg_index_t'(paddr[4:2]))
            REG_KEY_NUMBER: prdata = {26'd0, key_number_reg};
            REG_FILTER:     prdata = {24'd0, filter_ticks_reg};
            REG_LONG_HOLD:  prdata = {16'd0, long_hold_reg};
            REG_SHORT_HOLD: prdata = {16'd0, short_hold_reg};
            REG_REPEAT:     prdata = {24'd0, repeat_ticks_reg};
            default:        prdata = '0;
        endcase
    end

    assign out_free  = !out_valid_reg || rsp_ready;
    assign req_ready = !s1_valid_reg || out_free;
    assign req_fire  = req_valid && req_ready;
    assign do_tick   = req_fire && (req.opcode == OP_TICK);
    assign do_deq    = req_fire && (req.opcode == OP_DEQUEUE);
    assign do_clear  = req_fire && (req.opcode == OP_CLEAR);
    assign q_empty   = (rd_idx_reg == wr_idx_reg);

    // debounce, hold and repeat
    always_comb
    begin
        logic [8:0]  f9;
        logic [15:0] f16;
        logic        long_en;
        logic        short_en;
        logic [15:0] hold_eff;
        f9       = {1'b0, filter_ticks_reg};
        f16      = {8'd0, filter_ticks_reg};
        long_en  = long_hold_reg > f16;
        short_en = short_hold_reg > f16;
        hold_eff = hold_count_reg;

        filter_count_next = filter_count_reg;
        is_down_next      = is_down_reg;
        hold_count_next   = hold_count_reg;
        repeat_count_next = repeat_count_reg;
        tick_ev           = EV_NONE;
        push_a            = 1'b0;
        kind_a            = KIND_DOWN;
        push_b            = 1'b0;
        kind_b            = KIND_DOWN;

        if (req.key_pressed)
        begin
            if (filter_count_reg < f9)
            begin
                filter_count_next = f9;
            end
            else if (filter_count_reg < {filter_ticks_reg, 1'b0})
            begin
                filter_count_next = filter_count_reg + 9'd1;
            end
            else
            begin
                if (!is_down_reg)
                begin
                    is_down_next = 1'b1;
                    push_a       = 1'b1;
                    kind_a       = KIND_DOWN;
                    tick_ev      = EV_DOWN;
                    hold_eff     = f16;
                end
                hold_count_next = hold_eff;
                if (long_en)
                begin
                    if (hold_eff < long_hold_reg)
                    begin
                        hold_count_next = hold_eff + 16'd1;
                        if (hold_count_next == long_hold_reg)
                        begin
                            push_b  = 1'b1;
                            kind_b  = KIND_LONG;
                            tick_ev = EV_LONG;
                        end
                    end
                    else if (repeat_ticks_reg != 8'd0)
                    begin
                        repeat_count_next = repeat_count_reg + 8'd1;
                        if (repeat_count_next >= repeat_ticks_reg)
                        begin
                            repeat_count_next = '0;
                            push_b            = 1'b1;
                            kind_b            = KIND_DOWN;
                        end
                    end
                end
                else if (short_en && (hold_eff < short_hold_reg))
                begin
                    hold_count_next = hold_eff + 16'd1;
                end
            end
        end
        else
        begin
            if (short_en && (hold_count_reg >= short_hold_reg))
            begin
                push_a  = 1'b1;
                kind_a  = KIND_SHORT;
                tick_ev = EV_SHORT;
            end
            if (filter_count_reg > f9)
            begin
                filter_count_next = f9;
            end
            else if (filter_count_reg != 9'd0)
            begin
                filter_count_next = filter_count_reg - 9'd1;
            end
            else if (is_down_reg)
            begin
                is_down_next = 1'b0;
                push_b       = 1'b1;
                kind_b       = KIND_UP;
                tick_ev      = EV_UP;
            end
            hold_count_next   = '0;
            repeat_count_next = '0;
        end
    end

    // place up to two pushes in consecutive slots, one per bank
    assign slot0_v    = do_tick && (push_a || push_b);
    assign slot1_v    = do_tick && push_a && push_b;
    assign slot0_kind = push_a ? kind_a : kind_b;
    assign wr_idx_p1  = idx_inc(wr_idx_reg);

    always_comb
    begin
        bank0_we = 1'b0;
        bank0_wa = bank_addr(wr_idx_reg);
        bank0_wd = '{key: key_number_reg, kind: slot0_kind};
        bank1_we = 1'b0;
        bank1_wa = bank_addr(wr_idx_reg);
        bank1_wd = '{key: key_number_reg, kind: slot0_kind};
        if (slot0_v)
        begin
            if (wr_idx_reg[0])
            begin
                bank1_we = 1'b1;
            end
            else
            begin
                bank0_we = 1'b1;
            end
        end
        if (slot1_v)
        begin
            if (wr_idx_p1[0])
            begin
                bank1_we = 1'b1;
                bank1_wa = bank_addr(wr_idx_p1);
                bank1_wd = '{key: key_number_reg, kind: kind_b};
            end
            else
            begin
                bank0_we = 1'b1;
                bank0_wa = bank_addr(wr_idx_p1);
                bank0_wd = '{key: key_number_reg, kind: kind_b};
            end
        end
    end

    always_comb
    begin
        wr_idx_next = wr_idx_reg;
        rd_idx_next = rd_idx_reg;
        if (slot1_v)
        begin
            wr_idx_next = idx_inc(wr_idx_p1);
        end
        else if (slot0_v)
        begin
            wr_idx_next = wr_idx_p1;
        end
        if (do_deq && !q_empty)
        begin
            rd_idx_next = idx_inc(rd_idx_reg);
        end
        else if (do_clear)
        begin
            rd_idx_next = wr_idx_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            filter_count_reg <= '0;
            is_down_reg      <= 1'b0;
            hold_count_reg   <= '0;
            repeat_count_reg <= '0;
            rd_idx_reg       <= '0;
            wr_idx_reg       <= '0;
        end
        else
        begin
            if (do_tick)
            begin
                filter_count_reg <= filter_count_next;
                is_down_reg      <= is_down_next;
                hold_count_reg   <= hold_count_next;
                repeat_count_reg <= repeat_count_next;
            end
            rd_idx_reg <= rd_idx_next;
            wr_idx_reg <= wr_idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (bank0_we)
        begin
            bank0_mem[bank0_wa] <= bank0_wd;
        end
        if (do_deq)
        begin
            bank0_q_reg <= bank0_mem[bank_addr(rd_idx_reg)];
        end
    end

    always_ff @(posedge clk)
    begin
        if (bank1_we)
        begin
            bank1_mem[bank1_wa] <= bank1_wd;
        end
        if (do_deq)
        begin
            bank1_q_reg <= bank1_mem[bank_addr(rd_idx_reg)];
        end
    end

    // first stage: control for the pending RAM read
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (req_ready)
        begin
            s1_valid_reg <= req_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            s1_tick_event_reg  <= do_tick ? tick_ev : EV_NONE;
            s1_entry_valid_reg <= do_deq && !q_empty;
            s1_bank_reg        <= rd_idx_reg[0];
        end
    end

    // output stage
    assign q_sel = s1_bank_reg ? bank1_q_reg : bank0_q_reg;

    always_comb
    begin
        out_next.tick_event  = s1_tick_event_reg;
        out_next.entry_valid = s1_entry_valid_reg;
        out_next.entry_key   = s1_entry_valid_reg ? q_sel.key : 6'd0;
        out_next.entry_kind  = s1_entry_valid_reg ? q_sel.kind : KIND_DOWN;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_free)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free && s1_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

    assign rsp_valid = out_valid_reg;
    assign rsp       = out_reg;

    `KDEF_ASSERT(a_s1_hold, s1_valid_reg && !out_free |=> s1_valid_reg && $stable(s1_tick_event_reg))
    `KDEF_ASSERT_ALWAYS(a_rsp_excl, rsp_valid && rsp.entry_valid |-> rsp.tick_event == EV_NONE)
    `KDEF_ASSERT(a_clear_empties, do_clear |=> rd_idx_reg == wr_idx_reg)
    `KDEF_ASSERT(a_empty_deq, do_deq && q_empty |=> !s1_entry_valid_reg)

endmodule

### test/tb.sv
// Testbench for key_debounce_event_fifo: ticks, dequeues and clears over valid/ready,
// register writes over APB, each response checked against a debounce and queue model.
// Depends on kdef_pkg and the key_debounce_event_fifo RTL.
`timescale 1ns / 1ps

module tb;
    import kdef_pkg::*;

    localparam opcode_t OP_SPARE    = opcode_t'(2'd3);
    localparam int      CYCLE_LIMIT = 400000;

    logic                clk;
    logic                rst_n     = 1'b0;
    logic                req_valid = 1'b0;
    logic                req_ready;
    req_t                req       = '0;
    logic                rsp_valid;
    logic                rsp_ready = 1'b0;
    rsp_t                rsp;
    logic                psel      = 1'b0;
    logic                penable   = 1'b0;
    logic                pwrite    = 1'b0;
    logic [PADDR_W-1:0]  paddr     = '0;
    logic [PDATA_W-1:0]  pwdata    = '0;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    int          send_idle_pct = 11;
    int          recv_idle_pct = 70;
    int          items_sent    = 0;
    int          mismatches    = 0;
    int unsigned cycle_count   = 0;

    logic [5:0]       cfg_key    = 6'd0;
    logic [7:0]       cfg_filter = 8'd5;
    logic [15:0]      cfg_long   = 16'd0;
    logic [15:0]      cfg_short  = 16'd0;
    logic [7:0]       cfg_repeat = 8'd0;

    logic [8:0]       filt_cnt = '0;
    logic             key_down = 1'b0;
    logic [15:0]      hold_cnt = '0;
    logic [7:0]       rpt_cnt  = '0;
    entry_t           ev_ring [QUEUE_DEPTH] = '{default: '0};
    logic [IDX_W-1:0] rd_ptr = '0;
    logic [IDX_W-1:0] wr_ptr = '0;

    rsp_t rsp_due [$];

    key_debounce_event_fifo dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin
        wait (cycle_count >= CYCLE_LIMIT);
        $display("key_debounce_event_fifo: mismatch");
        $finish;
    end

    always @(posedge clk)
    begin
        rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
    end

    function automatic void queue_event(ev_kind_t kind);
        ev_ring[wr_ptr] = '{key: cfg_key, kind: kind};
        wr_ptr = IDX_W'((int'(wr_ptr) + 1) % QUEUE_DEPTH);
    endfunction

    function automatic tick_event_t debounce_step(logic pressed);
        tick_event_t shown;
        shown = EV_NONE;
        if (pressed)
        begin
            if (filt_cnt < {1'b0, cfg_filter})
                filt_cnt = {1'b0, cfg_filter};
            else if (filt_cnt < {cfg_filter, 1'b0})
                filt_cnt = filt_cnt + 9'd1;
            else
            begin
                if (!key_down)
                begin
                    key_down = 1'b1;
                    queue_event(KIND_DOWN);
                    shown = EV_DOWN;
                    hold_cnt = {8'd0, cfg_filter};
                end
                if (cfg_long > {8'd0, cfg_filter})
                begin
                    if (hold_cnt < cfg_long)
                    begin
                        hold_cnt = hold_cnt + 16'd1;
                        if (hold_cnt == cfg_long)
                        begin
                            queue_event(KIND_LONG);
                            shown = EV_LONG;
                        end
                    end
                    else if (cfg_repeat != 8'd0)
                    begin
                        rpt_cnt = rpt_cnt + 8'd1;
                        if (rpt_cnt >= cfg_repeat)
                        begin
                            rpt_cnt = '0;
                            queue_event(KIND_DOWN);
                        end
                    end
                end
                else if (cfg_short > {8'd0, cfg_filter} && hold_cnt < cfg_short)
                    hold_cnt = hold_cnt + 16'd1;
            end
        end
        else
        begin
            if (cfg_short > {8'd0, cfg_filter} && hold_cnt >= cfg_short)
            begin
                queue_event(KIND_SHORT);
                shown = EV_SHORT;
            end
            if (filt_cnt > {1'b0, cfg_filter})
                filt_cnt = {1'b0, cfg_filter};
            else if (filt_cnt != 9'd0)
                filt_cnt = filt_cnt - 9'd1;
            else if (key_down)
            begin
                key_down = 1'b0;
                queue_event(KIND_UP);
                shown = EV_UP;
            end
            hold_cnt = '0;
            rpt_cnt = '0;
        end
        return shown;
    endfunction

    function automatic rsp_t response_for(req_t item);
        rsp_t   r;
        entry_t head;
        r = '0;
        case (item.opcode)
            OP_TICK:
                r.tick_event = debounce_step(item.key_pressed);
            OP_DEQUEUE:
                if (rd_ptr != wr_ptr)
                begin
                    head = ev_ring[rd_ptr];
                    rd_ptr = IDX_W'((int'(rd_ptr) + 1) % QUEUE_DEPTH);
                    r.entry_valid = 1'b1;
                    r.entry_key = head.key;
                    r.entry_kind = head.kind;
                end
            OP_CLEAR:
                rd_ptr = wr_ptr;
            default:
                ;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what);
        if (mismatches < 100)
            $display("[%0t] %s", $time, what);
        mismatches++;
    endtask

    always @(posedge clk)
    begin : check_rsp
        rsp_t want;
        if (rst_n && rsp_valid && rsp_ready)
        begin
            if (rsp_due.size() == 0)
                report_mismatch("response transfer with nothing outstanding");
            else
            begin
                want = rsp_due.pop_front();
                if (rsp.tick_event !== want.tick_event)
                    report_mismatch($sformatf("tick_event %0d, wanted %0d",
                                              rsp.tick_event, want.tick_event));
                if (rsp.entry_valid !== want.entry_valid)
                    report_mismatch($sformatf("entry_valid %0d, wanted %0d",
                                              rsp.entry_valid, want.entry_valid));
                if (rsp.entry_key !== want.entry_key)
                    report_mismatch($sformatf("entry_key %0d, wanted %0d",
                                              rsp.entry_key, want.entry_key));
                if (rsp.entry_kind !== want.entry_kind)
                    report_mismatch($sformatf("entry_kind %0d, wanted %0d",
                                              rsp.entry_kind, want.entry_kind));
            end
        end
    end

    task automatic send_item(opcode_t op, logic level);
        req_t item;
        item.opcode = op;
        item.key_pressed = level;
        while ($urandom_range(99) < send_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req <= item;
        req_valid <= 1'b1;
        do @(posedge clk); while (!req_ready);
        rsp_due.push_back(response_for(item));
        if (op != OP_SPARE)
            items_sent++;
    endtask

    // hold off until every transfer has its response and the pipeline is empty
    task automatic settle();
        req_valid <= 1'b0;
        while (rsp_due.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(reg_index_t idx, logic [31:0] value);
        logic [31:0] field_mask;
        logic [31:0] bus_word;
        case (idx)
            REG_KEY_NUMBER:         field_mask = 32'h0000_003f;
            REG_FILTER, REG_REPEAT: field_mask = 32'h0000_00ff;
            default:                field_mask = 32'h0000_ffff;
        endcase
        bus_word = value & field_mask;
        if ($urandom_range(1) == 1)
            bus_word = bus_word | ($urandom & ~field_mask);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= bus_word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        case (idx)
            REG_KEY_NUMBER: cfg_key = bus_word[5:0];
            REG_FILTER:     cfg_filter = bus_word[7:0];
            REG_LONG_HOLD:  cfg_long = bus_word[15:0];
            REG_SHORT_HOLD: cfg_short = bus_word[15:0];
            REG_REPEAT:     cfg_repeat = bus_word[7:0];
            default:        ;
        endcase
    endtask

    task automatic set_config(logic [5:0] key, logic [7:0] filt, logic [15:0] hold_long,
                              logic [15:0] hold_short, logic [7:0] rpt);
        write_reg(REG_KEY_NUMBER, {26'd0, key});
        write_reg(REG_FILTER, {24'd0, filt});
        write_reg(REG_LONG_HOLD, {16'd0, hold_long});
        write_reg(REG_SHORT_HOLD, {16'd0, hold_short});
        write_reg(REG_REPEAT, {24'd0, rpt});
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_config(int slot);
        logic [7:0]  f;
        logic [15:0] lh;
        logic [15:0] sh;
        logic [7:0]  rp;
        if (slot == 0)
            set_config(6'd63, 8'd255, 16'hffff, 16'hffff, 8'd255);
        else if (slot == 1)
            set_config(6'd0, 8'd1, 16'd0, 16'd0, 8'd0);
        else
        begin
            f = ($urandom_range(9) < 7) ? 8'($urandom_range(1, 4))
                                        : 8'($urandom_range(0, 12));
            case ($urandom_range(5))
                0, 1:    lh = 16'(f) + 16'($urandom_range(1, 10));
                2:       lh = '0;
                3:       lh = 16'($urandom_range(0, f));
                4:       lh = 16'($urandom);
                default: lh = 16'(f) + 16'd1;
            endcase
            case ($urandom_range(5))
                0, 1:    sh = 16'(f) + 16'($urandom_range(1, 10));
                2:       sh = '0;
                3:       sh = 16'($urandom_range(0, f));
                4:       sh = 16'($urandom);
                default: sh = 16'(f) + 16'd1;
            endcase
            case ($urandom_range(4))
                0:       rp = '0;
                1, 2:    rp = 8'($urandom_range(1, 4));
                3:       rp = 8'd255;
                default: rp = 8'($urandom_range(0, 255));
            endcase
            set_config(6'($urandom_range(63)), f, lh, sh, rp);
        end
    endtask

    task automatic key_episode(int deq_pct, int hold, int rel);
        repeat ($urandom_range(0, 3)) send_item(OP_TICK, 1'($urandom_range(1)));
        repeat (hold)
        begin
            if ($urandom_range(99) < deq_pct)
                send_item(OP_DEQUEUE, 1'($urandom_range(1)));
            send_item(OP_TICK, 1'b1);
        end
        repeat ($urandom_range(0, 2)) send_item(OP_TICK, 1'($urandom_range(1)));
        repeat (rel)
        begin
            if ($urandom_range(99) < deq_pct)
                send_item(OP_DEQUEUE, 1'($urandom_range(1)));
            send_item(OP_TICK, 1'b0);
        end
    endtask

    task automatic run_traffic(int n);
        int start;
        int pick;
        int span;
        start = items_sent;
        span = 2 * int'(cfg_filter) + 24;
        if (span > 80)
            span = 80;
        while (items_sent - start < n)
        begin
            pick = $urandom_range(99);
            if (pick < 60)
                key_episode(25, $urandom_range(1, span),
                            $urandom_range(1, int'(cfg_filter) + 3));
            else if (pick < 72)
                repeat ($urandom_range(1, 6))
                    send_item(OP_DEQUEUE, 1'($urandom_range(1)));
            else if (pick < 76)
                send_item(OP_CLEAR, 1'($urandom_range(1)));
            else if (pick < 86)
                key_episode(0, $urandom_range(20, 40),
                            $urandom_range(1, int'(cfg_filter) + 3));
            else
                repeat ($urandom_range(1, 8))
                    send_item(opcode_t'($urandom_range(3)), 1'($urandom_range(1)));
        end
    endtask

    task automatic test_empty_queue();
        send_item(OP_DEQUEUE, 1'b0);
        send_item(OP_SPARE, 1'b1);
        send_item(OP_CLEAR, 1'b1);
    endtask

    task automatic test_zero_filter();
        settle();
        set_config(6'd63, 8'd0, 16'd0, 16'd1, 8'd0);
        send_item(OP_TICK, 1'b1);
        send_item(OP_TICK, 1'b0);
        repeat (4) send_item(OP_DEQUEUE, 1'b0);
    endtask

    task automatic test_short_press();
        settle();
        set_config(6'd0, 8'd1, 16'd0, 16'd3, 8'd0);
        repeat (4) send_item(OP_TICK, 1'b1);
        repeat (3) send_item(OP_TICK, 1'b0);
        repeat (3) send_item(OP_DEQUEUE, 1'b1);
    endtask

    task automatic test_long_repeat();
        settle();
        set_config(6'd21, 8'd1, 16'd2, 16'd0, 8'd2);
        repeat (5) send_item(OP_TICK, 1'b1);
        repeat (3) send_item(OP_TICK, 1'b0);
        repeat (2) send_item(OP_DEQUEUE, 1'b0);
        send_item(OP_CLEAR, 1'b0);
        send_item(OP_DEQUEUE, 1'b1);
    endtask

    task automatic test_random_traffic();
        for (int slot = 0; slot < 4; slot++)
        begin
            settle();
            random_config(slot);
            run_traffic(80);
        end
    endtask

    task automatic test_slow_filter();
        settle();
        set_config(6'($urandom_range(63)), 8'd255, 16'hffff, 16'd0, 8'd255);
        repeat (270) send_item(OP_TICK, 1'b1);
        repeat (2) send_item(OP_DEQUEUE, 1'b0);
        repeat (270) send_item(OP_TICK, 1'b0);
        repeat (3) send_item(OP_DEQUEUE, 1'b1);
    endtask

    initial
    begin
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_queue();
        test_zero_filter();
        test_short_press();
        test_long_repeat();
        test_random_traffic();
        send_idle_pct = 70;
        recv_idle_pct = 11;
        test_random_traffic();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_traffic();
        test_slow_filter();
        settle();
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("key_debounce_event_fifo: match");
        else
            $display("key_debounce_event_fifo: mismatch");
        $finish;
    end

endmodule
